// ----- rtl/core/vlmr_pkg.sv -----
// ----------------------------------------------------------------------------
// vlmr_pkg
// Shared constants, types and helpers of the variable-length message ring.
// ----------------------------------------------------------------------------
package vlmr_pkg;

    // Ring geometry; RING_BYTES must be a power of two so pointers wrap freely.
    localparam int RING_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;

    localparam int PTR_W   = $clog2(RING_BYTES);
    localparam int AVAIL_W = PTR_W + 1;
    localparam int BYTE_W  = 8;
    localparam int TAG_W   = 48;
    localparam int LEN_W   = 6;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 3;

    localparam int TAG_BYTES = TAG_W / BYTE_W;
    // Last header byte index that carries tag content.
    localparam int TAG_LAST  = (HEADER_BYTES - 1 < TAG_BYTES) ? HEADER_BYTES - 1 : TAG_BYTES;
    localparam int IDX_W     = (LEN_W > $clog2(HEADER_BYTES)) ? LEN_W : $clog2(HEADER_BYTES);

    typedef enum logic [OP_W-1:0] {
        OP_POST = 2'd0,
        OP_BYTE = 2'd1,
        OP_POLL = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_POST_OK    = 3'd0,
        KIND_POST_FULL  = 3'd1,
        KIND_POLL_EMPTY = 3'd2,
        KIND_HEADER     = 3'd3,
        KIND_PAYLOAD    = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POST_CHK,
        ST_HDR_WR,
        ST_POST_RES,
        ST_POLL_CHK,
        ST_EMPTY_RES,
        ST_HDR_RD,
        ST_HDR_CAP,
        ST_HDR_RES,
        ST_PAY_RD,
        ST_PAY_RES
    } state_t;

    typedef struct packed {
        logic  capture;      // latch the accepted request
        logic  pay_write;    // store a payload byte of the open post
        logic  post_check;   // close any open post, record the full decision
        logic  hdr_write;    // write one header byte
        logic  hdr_commit;   // finish the header of an accepted post
        logic  poll_start;   // clear the tag and byte index for a poll
        logic  mem_read;     // issue a ring read
        logic  rd_sel_pay;   // read address is in the payload area
        logic  hdr_capture;  // take the read byte into the header fields
        logic  idx_inc;      // advance the byte index
        logic  idx_clr;      // restart the byte index
        logic  rd_advance;   // move the read pointer past the polled message
        logic  out_load;     // load the output register
        kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic ring_full;
        logic ring_empty;
        logic post_reject;
        logic idx_hdr_end;
        logic idx_tag_end;
        logic hdr_last;
        logic pay_last;
        logic out_free;
    } status_t;

    // Byte idx of the stored header: length first, then the tag LSB first.
    function automatic logic [BYTE_W-1:0] header_byte(
        input logic [IDX_W-1:0] idx,
        input logic [LEN_W-1:0] len,
        input logic [TAG_W-1:0] tag
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        if (idx == '0)
        begin
            b = BYTE_W'(len);
        end
        else
        begin
            for (int i = 0; i < TAG_BYTES; i++)
            begin
                if (idx == IDX_W'(i + 1))
                begin
                    b = tag[i*BYTE_W +: BYTE_W];
                end
            end
        end
        return b;
    endfunction

endpackage

// ----- rtl/core/vlmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// vlmr_ctrl
// Sequencer for post, payload and poll requests of the message ring.
// ----------------------------------------------------------------------------
module vlmr_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [vlmr_pkg::OP_W-1:0]     op,
    input  vlmr_pkg::status_t             status,
    output vlmr_pkg::cmd_t                cmd
);
    import vlmr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_POST: state_next = ST_POST_CHK;
                        OP_POLL: state_next = ST_POLL_CHK;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POST_CHK:
            begin
                state_next = status.ring_full ? ST_POST_RES : ST_HDR_WR;
            end
            ST_HDR_WR:
            begin
                if (status.idx_hdr_end)
                begin
                    state_next = ST_POST_RES;
                end
            end
            ST_POST_RES, ST_EMPTY_RES:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POLL_CHK:
            begin
                state_next = status.ring_empty ? ST_EMPTY_RES : ST_HDR_RD;
            end
            ST_HDR_RD:
            begin
                state_next = ST_HDR_CAP;
            end
            ST_HDR_CAP:
            begin
                state_next = status.idx_tag_end ? ST_HDR_RES : ST_HDR_RD;
            end
            ST_HDR_RES:
            begin
                if (status.out_free)
                begin
                    state_next = status.hdr_last ? ST_IDLE : ST_PAY_RD;
                end
            end
            ST_PAY_RD:
            begin
                state_next = ST_PAY_RES;
            end
            ST_PAY_RES:
            begin
                if (status.out_free)
                begin
                    state_next = status.pay_last ? ST_IDLE : ST_PAY_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.out_kind = KIND_POST_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture   = accept;
                cmd.idx_clr   = accept;
                cmd.pay_write = accept && (op == OP_BYTE);
            end
            ST_POST_CHK:
            begin
                cmd.post_check = 1'b1;
            end
            ST_HDR_WR:
            begin
                cmd.hdr_write  = 1'b1;
                cmd.idx_inc    = 1'b1;
                cmd.hdr_commit = status.idx_hdr_end;
            end
            ST_POST_RES:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = status.post_reject ? KIND_POST_FULL : KIND_POST_OK;
            end
            ST_EMPTY_RES:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = KIND_POLL_EMPTY;
            end
            ST_POLL_CHK:
            begin
                cmd.poll_start = !status.ring_empty;
            end
            ST_HDR_RD:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_HDR_CAP:
            begin
                cmd.hdr_capture = 1'b1;
                cmd.idx_inc     = !status.idx_tag_end;
            end
            ST_HDR_RES:
            begin
                cmd.out_load   = status.out_free;
                cmd.out_kind   = KIND_HEADER;
                cmd.rd_advance = status.out_free && status.hdr_last;
                cmd.idx_clr    = status.out_free && !status.hdr_last;
            end
            ST_PAY_RD:
            begin
                cmd.mem_read   = 1'b1;
                cmd.rd_sel_pay = 1'b1;
            end
            ST_PAY_RES:
            begin
                cmd.out_load   = status.out_free;
                cmd.out_kind   = KIND_PAYLOAD;
                cmd.rd_advance = status.out_free && status.pay_last;
                cmd.idx_inc    = status.out_free && !status.pay_last;
            end
            default:
            begin
                cmd.capture = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/vlmr_datapath.sv -----
// ----------------------------------------------------------------------------
// vlmr_datapath
// Ring memory, pointers, post bookkeeping and the output register.
// ----------------------------------------------------------------------------
module vlmr_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  vlmr_pkg::cmd_t                  cmd,
    output vlmr_pkg::status_t               status,
    input  logic [vlmr_pkg::TAG_W-1:0]      header_tag,
    input  logic [vlmr_pkg::LEN_W-1:0]      payload_len,
    input  logic [vlmr_pkg::BYTE_W-1:0]     payload_in,
    input  logic [vlmr_pkg::LEN_W-1:0]      read_limit,
    output logic [vlmr_pkg::KIND_W-1:0]     kind,
    output logic [vlmr_pkg::TAG_W-1:0]      tag_out,
    output logic [vlmr_pkg::LEN_W-1:0]      len_out,
    output logic [vlmr_pkg::BYTE_W-1:0]     byte_out,
    output logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready
);
    import vlmr_pkg::*;

    logic [BYTE_W-1:0] ring_mem [RING_BYTES];

    // Control state
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LEN_W-1:0] pending_reg, pending_next;
    logic             open_reg, open_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state
    logic [TAG_W-1:0]  req_tag_reg, req_tag_next;
    logic [LEN_W-1:0]  req_len_reg, req_len_next;
    logic [LEN_W-1:0]  limit_reg, limit_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic              reject_reg, reject_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [TAG_W-1:0]  tag_out_reg, tag_out_next;
    logic [LEN_W-1:0]  len_out_reg, len_out_next;
    logic [BYTE_W-1:0] byte_out_reg, byte_out_next;
    logic              last_reg, last_next;

    logic [PTR_W-1:0]   diff;
    logic [AVAIL_W-1:0] avail;
    logic [AVAIL_W-1:0] need;
    logic [LEN_W-1:0]   n_bytes;
    logic               pay_ok;
    logic               mem_we;
    logic [PTR_W-1:0]   wr_addr;
    logic [BYTE_W-1:0]  wr_data;
    logic [PTR_W-1:0]   rd_addr;

    // Free space and need
    assign diff    = rd_ptr_reg - wr_ptr_reg;
    assign avail   = (diff == '0) ? AVAIL_W'(RING_BYTES) : {1'b0, diff};
    assign need    = AVAIL_W'(HEADER_BYTES) + AVAIL_W'(req_len_reg);
    assign n_bytes = (len_reg < limit_reg) ? len_reg : limit_reg;
    assign pay_ok  = cmd.pay_write && open_reg && (pending_reg != '0);

    assign status.ring_full   = (need >= avail);
    assign status.ring_empty  = (rd_ptr_reg == wr_ptr_reg);
    assign status.post_reject = reject_reg;
    assign status.idx_hdr_end = (idx_reg == IDX_W'(HEADER_BYTES - 1));
    assign status.idx_tag_end = (idx_reg == IDX_W'(TAG_LAST));
    assign status.hdr_last    = (n_bytes == '0);
    assign status.pay_last    = ((IDX_W+1)'(idx_reg) + (IDX_W+1)'(1)) == (IDX_W+1)'(n_bytes);
    assign status.out_free    = !out_valid_reg || out_ready;

    // Ring write and read ports
    always_comb
    begin
        mem_we  = cmd.hdr_write || pay_ok;
        wr_addr = wr_ptr_reg + PTR_W'(HEADER_BYTES) + PTR_W'(cur_len_reg)
                  - PTR_W'(pending_reg);
        wr_data = payload_in;
        if (cmd.hdr_write)
        begin
            wr_addr = wr_ptr_reg + PTR_W'(idx_reg);
            wr_data = header_byte(idx_reg, req_len_reg, req_tag_reg);
        end
        rd_addr = rd_ptr_reg + PTR_W'(idx_reg);
        if (cmd.rd_sel_pay)
        begin
            rd_addr = rd_ptr_reg + PTR_W'(HEADER_BYTES) + PTR_W'(idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        pending_next   = pending_reg;
        open_next      = open_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        req_tag_next   = req_tag_reg;
        req_len_next   = req_len_reg;
        limit_next     = limit_reg;
        cur_len_next   = cur_len_reg;
        reject_next    = reject_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        kind_next      = kind_reg;
        tag_out_next   = tag_out_reg;
        len_out_next   = len_out_reg;
        byte_out_next  = byte_out_reg;
        last_next      = last_reg;

        if (cmd.capture)
        begin
            req_tag_next = header_tag;
            req_len_next = payload_len;
            limit_next   = read_limit;
        end

        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        // Payload byte of the open post; commit on the final byte
        if (pay_ok)
        begin
            pending_next = pending_reg - LEN_W'(1);
            if (pending_reg == LEN_W'(1))
            begin
                wr_ptr_next = wr_ptr_reg + PTR_W'(HEADER_BYTES) + PTR_W'(cur_len_reg);
                open_next   = 1'b0;
            end
        end

        // A new header drops any unfinished post
        if (cmd.post_check)
        begin
            open_next    = 1'b0;
            pending_next = '0;
            reject_next  = status.ring_full;
        end

        if (cmd.hdr_commit)
        begin
            if (req_len_reg == '0)
            begin
                wr_ptr_next = wr_ptr_reg + PTR_W'(HEADER_BYTES);
            end
            else
            begin
                open_next    = 1'b1;
                pending_next = req_len_reg;
                cur_len_next = req_len_reg;
            end
        end

        if (cmd.poll_start)
        begin
            tag_next = '0;
            idx_next = '0;
        end

        if (cmd.hdr_capture)
        begin
            if (idx_reg == '0)
            begin
                len_next = rdata_reg[LEN_W-1:0];
            end
            for (int b = 0; b < TAG_BYTES; b++)
            begin
                if (idx_reg == IDX_W'(b + 1))
                begin
                    tag_next[b*BYTE_W +: BYTE_W] = rdata_reg;
                end
            end
        end

        if (cmd.rd_advance)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(HEADER_BYTES) + PTR_W'(len_reg);
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            kind_next      = cmd.out_kind;
            tag_out_next   = '0;
            len_out_next   = '0;
            byte_out_next  = '0;
            last_next      = 1'b1;
            unique case (cmd.out_kind)
                KIND_HEADER:
                begin
                    tag_out_next = tag_reg;
                    len_out_next = len_reg;
                    last_next    = status.hdr_last;
                end
                KIND_PAYLOAD:
                begin
                    byte_out_next = rdata_reg;
                    last_next     = status.pay_last;
                end
                default:
                begin
                    last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            pending_reg   <= '0;
            open_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            pending_reg   <= pending_next;
            open_reg      <= open_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_tag_reg  <= req_tag_next;
        req_len_reg  <= req_len_next;
        limit_reg    <= limit_next;
        cur_len_reg  <= cur_len_next;
        reject_reg   <= reject_next;
        tag_reg      <= tag_next;
        len_reg      <= len_next;
        kind_reg     <= kind_next;
        tag_out_reg  <= tag_out_next;
        len_out_reg  <= len_out_next;
        byte_out_reg <= byte_out_next;
        last_reg     <= last_next;
    end

    assign kind      = kind_reg;
    assign tag_out   = tag_out_reg;
    assign len_out   = len_out_reg;
    assign byte_out  = byte_out_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/variable_length_message_ring_core.sv -----
// ----------------------------------------------------------------------------
// variable_length_message_ring_core
// Byte ring of variable-length messages with post, payload and poll requests.
// ----------------------------------------------------------------------------
// The ring holds RING_BYTES bytes in one single-port-write, registered-read
// memory; each message is HEADER_BYTES header bytes (length, then the tag LSB
// first) followed by its payload, wrapping at the end of the ring. Requests
// are taken one at a time, and a result state waits while the output register
// is full and out_ready is low. A payload byte is taken in idle and gives no
// result. A post header that fits writes its HEADER_BYTES bytes into the
// memory one byte per cycle; every post gives one result, ok or full. A poll
// reads the length and tag bytes, then min(length, read_limit) payload bytes:
// every header and payload byte goes through the one memory read port, a read
// state then a capture or result state. An empty poll gives one empty result.
// Results sit in an output register, so a new request is accepted while the
// last result still waits. No clearing pass runs after reset: polls only ever
// read bytes that an earlier post has written.
// ----------------------------------------------------------------------------
module variable_length_message_ring_core
(
    input  logic                            clk,
    input  logic                            rst_n,

    // Request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [vlmr_pkg::OP_W-1:0]       op,
    input  logic [vlmr_pkg::TAG_W-1:0]      header_tag,
    input  logic [vlmr_pkg::LEN_W-1:0]      payload_len,
    input  logic [vlmr_pkg::BYTE_W-1:0]     payload_in,
    input  logic [vlmr_pkg::LEN_W-1:0]      read_limit,

    // Result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [vlmr_pkg::KIND_W-1:0]     kind,
    output logic [vlmr_pkg::TAG_W-1:0]      tag_out,
    output logic [vlmr_pkg::LEN_W-1:0]      len_out,
    output logic [vlmr_pkg::BYTE_W-1:0]     byte_out,
    output logic                            last
);
    import vlmr_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer: accepts requests in idle, then steps the datapath through
    // the header write, header read and payload stream of one request.
    vlmr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    // Ring memory, read and write pointers, open-post tracking and the
    // output register.
    vlmr_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .header_tag  (header_tag),
        .payload_len (payload_len),
        .payload_in  (payload_in),
        .read_limit  (read_limit),
        .kind        (kind),
        .tag_out     (tag_out),
        .len_out     (len_out),
        .byte_out    (byte_out),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

// ----- bench/tb_variable_length_message_ring_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_length_message_ring_core
// Self-checking bench for the variable-length message ring core.
// ----------------------------------------------------------------------------
// A bench-side copy of the ring (bytes, oldest and commit pointers, open post)
// is updated on every accepted request and queues the replies it predicts.
// A monitor compares every reply the core hands out, field by field, with the
// oldest queued reply. The stimulus runs a short directed set, a backlog of
// polls under a long receiver hold-off, and random message traffic under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_variable_length_message_ring_core;

    import vlmr_pkg::*;

    // The one op code the package leaves unnamed; the core must ignore it.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int MAX_LEN         = (1 << LEN_W) - 1;
    localparam int RESET_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    // Leave room past the longest poll.
    localparam int TAIL_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 20000;

    typedef struct packed {
        kind_t              kind;
        logic [TAG_W-1:0]   tag;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } ring_reply_t;

    logic                   clk;
    logic                   rst_n;

    logic                   in_valid;
    logic                   in_ready;
    logic [OP_W-1:0]        op;
    logic [TAG_W-1:0]       header_tag;
    logic [LEN_W-1:0]       payload_len;
    logic [BYTE_W-1:0]      payload_in;
    logic [LEN_W-1:0]       read_limit;

    logic                   out_valid;
    logic                   out_ready;
    logic [KIND_W-1:0]      kind;
    logic [TAG_W-1:0]       tag_out;
    logic [LEN_W-1:0]       len_out;
    logic [BYTE_W-1:0]      byte_out;
    logic                   last;

    // Bench copy of the ring contents and pointers.
    logic [BYTE_W-1:0]      ring_mem [RING_BYTES];
    logic [PTR_W-1:0]       oldest_ptr;     // start of the oldest committed message
    logic [PTR_W-1:0]       commit_ptr;     // end of the committed messages
    int                     bytes_owed;     // payload bytes the open post still takes
    logic                   post_active;

    ring_reply_t            ring_replies [$];

    int                     error_count;
    int                     sender_idle_pct;
    int                     receiver_stall_pct;
    int                     hold_off_left;

    variable_length_message_ring_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .header_tag  (header_tag),
        .payload_len (payload_len),
        .payload_in  (payload_in),
        .read_limit  (read_limit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .tag_out     (tag_out),
        .len_out     (len_out),
        .byte_out    (byte_out),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Ring prediction
    // ------------------------------------------------------------------------

    // Free bytes; an empty ring reports all of it.
    function automatic int ring_space();
        if (oldest_ptr <= commit_ptr)
        begin
            return RING_BYTES - int'(commit_ptr) + int'(oldest_ptr);
        end
        return int'(oldest_ptr) - int'(commit_ptr);
    endfunction

    function automatic void push_reply(
        input kind_t              k,
        input logic [TAG_W-1:0]   t,
        input logic [LEN_W-1:0]   l,
        input logic [BYTE_W-1:0]  d,
        input logic               lst
    );
        ring_replies.push_back('{kind: k, tag: t, len: l, data: d, last: lst});
    endfunction

    // Update the ring copy for one accepted request and queue its replies.
    function automatic void apply_ring_request(
        input logic [OP_W-1:0]    req_op,
        input logic [TAG_W-1:0]   req_tag,
        input logic [LEN_W-1:0]   req_len,
        input logic [BYTE_W-1:0]  req_byte,
        input logic [LEN_W-1:0]   req_limit
    );
        int                msg_len;
        int                offset;
        int                count;
        logic [TAG_W-1:0]  tag_acc;
        case (req_op)
            OP_POST:
            begin
                // Any unfinished post is dropped before the room check.
                post_active = 1'b0;
                bytes_owed  = 0;
                if (HEADER_BYTES + int'(req_len) >= ring_space())
                begin
                    push_reply(KIND_POST_FULL, '0, '0, '0, 1'b1);
                end
                else
                begin
                    ring_mem[commit_ptr] = BYTE_W'(req_len);
                    for (int i = 1; i < HEADER_BYTES; i++)
                    begin
                        if (i <= TAG_BYTES)
                        begin
                            ring_mem[PTR_W'(commit_ptr + i)] = req_tag[BYTE_W*(i-1) +: BYTE_W];
                        end
                        else
                        begin
                            ring_mem[PTR_W'(commit_ptr + i)] = '0;
                        end
                    end
                    if (req_len == '0)
                    begin
                        commit_ptr = PTR_W'(commit_ptr + HEADER_BYTES);
                    end
                    else
                    begin
                        post_active = 1'b1;
                        bytes_owed  = int'(req_len);
                    end
                    push_reply(KIND_POST_OK, '0, '0, '0, 1'b1);
                end
            end
            OP_BYTE:
            begin
                if (post_active && bytes_owed != 0)
                begin
                    msg_len = int'(ring_mem[commit_ptr][LEN_W-1:0]);
                    offset  = HEADER_BYTES + msg_len - bytes_owed;
                    ring_mem[PTR_W'(commit_ptr + offset)] = req_byte;
                    bytes_owed--;
                    if (bytes_owed == 0)
                    begin
                        commit_ptr  = PTR_W'(commit_ptr + HEADER_BYTES + msg_len);
                        post_active = 1'b0;
                    end
                end
            end
            OP_POLL:
            begin
                if (oldest_ptr == commit_ptr)
                begin
                    push_reply(KIND_POLL_EMPTY, '0, '0, '0, 1'b1);
                end
                else
                begin
                    msg_len = int'(ring_mem[oldest_ptr][LEN_W-1:0]);
                    tag_acc = '0;
                    for (int i = 1; i < HEADER_BYTES && i <= TAG_BYTES; i++)
                    begin
                        tag_acc[BYTE_W*(i-1) +: BYTE_W] = ring_mem[PTR_W'(oldest_ptr + i)];
                    end
                    count = (msg_len < int'(req_limit)) ? msg_len : int'(req_limit);
                    push_reply(KIND_HEADER, tag_acc, LEN_W'(msg_len), '0, count == 0);
                    for (int i = 0; i < count; i++)
                    begin
                        push_reply(KIND_PAYLOAD, '0, '0,
                                   ring_mem[PTR_W'(oldest_ptr + HEADER_BYTES + i)],
                                   i + 1 == count);
                    end
                    // Skip the whole payload, not just the part returned.
                    oldest_ptr = PTR_W'(oldest_ptr + HEADER_BYTES + msg_len);
                end
            end
            default:
            begin
                // Spare op code: no effect, no reply.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'({$urandom, $urandom});
    endfunction

    // Mostly short payloads, now and then a long one up to the field maximum.
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 70)
        begin
            return $urandom_range(6, 0);
        end
        if (roll < 95)
        begin
            return $urandom_range(20, 7);
        end
        return $urandom_range(MAX_LEN, 21);
    endfunction

    // Offer one request and hold it until the core takes it. Valid stays high
    // on return so back-to-back requests need no gap; whoever waits next
    // drops it.
    task automatic send_request(
        input logic [OP_W-1:0]    req_op,
        input logic [TAG_W-1:0]   req_tag,
        input logic [LEN_W-1:0]   req_len,
        input logic [BYTE_W-1:0]  req_byte,
        input logic [LEN_W-1:0]   req_limit
    );
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= req_op;
        header_tag  <= req_tag;
        payload_len <= req_len;
        payload_in  <= req_byte;
        read_limit  <= req_limit;
        do
            @(posedge clk);
        while (!in_ready);
        apply_ring_request(req_op, req_tag, req_len, req_byte, req_limit);
    endtask

    // Fields a request does not use still toggle with random values.
    task automatic post_header(input logic [TAG_W-1:0] tag, input int len);
        send_request(OP_POST, tag, LEN_W'(len), BYTE_W'($urandom), LEN_W'($urandom));
    endtask

    task automatic post_byte(input logic [BYTE_W-1:0] data);
        send_request(OP_BYTE, rand_tag(), LEN_W'($urandom), data, LEN_W'($urandom));
    endtask

    task automatic poll_ring(input int limit);
        send_request(OP_POLL, rand_tag(), LEN_W'($urandom), BYTE_W'($urandom), LEN_W'(limit));
    endtask

    task automatic send_message(input logic [TAG_W-1:0] tag, input int len);
        post_header(tag, len);
        repeat (len) post_byte(BYTE_W'($urandom));
    endtask

    // Drop valid and hold until every predicted reply has come back. Always
    // wait on the clock first so a following request never lowers and
    // raises valid in the same step.
    task automatic wait_ring_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (ring_replies.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        poll_ring(MAX_LEN);                         // empty ring
        send_request(OP_SPARE, '1, '1, '1, '1);     // spare op: ignored
        post_byte(8'hFF);                           // stray byte: ignored
        post_header('1, 0);                         // empty payload commits at once
        poll_ring(0);
        post_header('0, 2);
        post_byte(8'h00);
        post_byte(8'hFF);
        poll_ring(MAX_LEN);
        send_message(48'h0123_4567_89AB, 3);
        poll_ring(1);                               // read shorter than the payload
        post_header(rand_tag(), 4);
        post_byte(8'h5A);
        poll_ring(MAX_LEN);                         // open post stays invisible
        post_header(rand_tag(), 1);                 // abandons the open post
        post_byte(8'hC3);
        poll_ring(MAX_LEN);
        poll_ring(MAX_LEN);
    endtask

    // Post a few messages, then poll them while the receiver holds off, so
    // replies back up into the core and its input stalls.
    task automatic test_backlog();
        sender_idle_pct    = 7;
        receiver_stall_pct = 7;
        repeat (3) send_message(rand_tag(), $urandom_range(6, 1));
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (3) poll_ring(MAX_LEN);
        poll_ring(MAX_LEN);
    endtask

    // Mostly complete messages and polls, with abandoned posts, polls in the
    // middle of a post, stray bytes and the spare op mixed in.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int item_goal);
        int sent;
        int roll;
        int len;
        int cut;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_goal)
        begin
            roll = $urandom_range(99, 0);
            len  = pick_length();
            cut  = $urandom_range(len, 0);
            if (roll < 45)
            begin
                send_message(rand_tag(), len);
                sent += len + 1;
            end
            else if (roll < 75)
            begin
                poll_ring($urandom_range(MAX_LEN, 0));
                sent += 1;
            end
            else if (roll < 85)
            begin
                // May stop short; the next header drops an unfinished post.
                post_header(rand_tag(), len);
                repeat (cut) post_byte(BYTE_W'($urandom));
                sent += cut + 1;
            end
            else if (roll < 93)
            begin
                post_header(rand_tag(), len);
                repeat (cut) post_byte(BYTE_W'($urandom));
                poll_ring($urandom_range(MAX_LEN, 0));
                repeat (len - cut) post_byte(BYTE_W'($urandom));
                sent += len + 2;
            end
            else if ($urandom_range(1, 0) == 0)
            begin
                post_byte(BYTE_W'($urandom));
            end
            else
            begin
                send_request(OP_SPARE, rand_tag(), LEN_W'($urandom), BYTE_W'($urandom),
                             LEN_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Reply side
    // ------------------------------------------------------------------------

    // Stall at random, or hold off for a counted stretch when a test asks.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
            end
        end
    end

    task automatic check_field(input string field_name, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field_name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        ring_reply_t want;
        if (out_valid && out_ready)
        begin
            if (ring_replies.size() == 0)
            begin
                error_count++;
                $display("%0t: reply with nothing outstanding: expected none, actual kind %0d",
                         $time, kind);
            end
            else
            begin
                want = ring_replies.pop_front();
                check_field("kind", TAG_W'(want.kind), TAG_W'(kind));
                check_field("tag_out", want.tag, tag_out);
                check_field("len_out", TAG_W'(want.len), TAG_W'(len_out));
                check_field("byte_out", TAG_W'(want.data), TAG_W'(byte_out));
                check_field("last", TAG_W'(want.last), TAG_W'(last));
            end
        end
    end

    // Count edges where neither channel moves a request or a reply.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("%0t: watchdog: no handshake for %0d cycles, %0d replies outstanding",
                 $time, WATCHDOG_LIMIT, ring_replies.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = 0;
        oldest_ptr         = '0;
        commit_ptr         = '0;
        bytes_owed         = 0;
        post_active        = 1'b0;
        for (int i = 0; i < RING_BYTES; i++)
        begin
            ring_mem[i] = '0;
        end

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_POST;
        header_tag  <= '0;
        payload_len <= '0;
        payload_in  <= '0;
        read_limit  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_ring_idle();
        test_backlog();
        wait_ring_idle();
        test_random_traffic(0, 0, 40);
        wait_ring_idle();
        test_random_traffic(65, 0, 40);
        wait_ring_idle();
        test_random_traffic(0, 65, 40);
        wait_ring_idle();
        test_random_traffic(7, 7, 40);
        wait_ring_idle();

        // Let any late reply show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && ring_replies.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
